// ===== hw/rtl/pwt_pkg.sv =====
// Package for the priority-ordered warning table.
// Holds field widths, the operation codes and the command, result and entry words.
// No dependencies.
`timescale 1ns / 1ps

package pwt_pkg;

    localparam int ID_W         = 8;
    localparam int PRI_W        = 8;
    localparam int COUNT_W      = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [ID_W-1:0]    warning_id;
        logic [PRI_W-1:0]   new_priority;
    } cmd_t;

    typedef struct packed {
        logic               done_ok;
        logic               table_full;
        logic [PRI_W-1:0]   found_priority;
        logic               head_valid;
        logic [ID_W-1:0]    head_id;
        logic [PRI_W-1:0]   head_priority;
        logic [ID_W-1:0]    tail_id;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRI_W-1:0]   pri;
    } entry_t;

endpackage

// ===== hw/rtl/pwt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pwt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/priority_ordered_warning_table.sv =====
// Top level of the priority-ordered warning table: sequencer walking the entry RAM.
// Depends on pwt_pkg (types, codes) and pwt_ram (entry storage).
`timescale 1ns / 1ps
//
// Channel   Handshake        Word
// -------   --------------   ----------------------------------------------
// command   start / busy     cmd    (mode, warning_id, new_priority)
// result    done (strobe)    result (flags, found priority, head, tail, count)
//
// One RAM read port sets the pace: each visited entry is read in ST_READ and
// gets its modify/write step in ST_PROC. Insert walks up to the free slot past the end,
// remove walks every entry and lookup stops at the hit (the last entry on a miss);
// a rejected insert and clear skip the walk. Head and tail are fetched from the
// RAM after the walk; an operation that leaves the table empty skips the fetch.
// Reset clears the count only; the RAM is not swept, and stale slots beyond the count
// never reach a result. done is high for one cycle; the receiver cannot stall.

module priority_ordered_warning_table #(
    parameter int CAPACITY = pwt_pkg::CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  pwt_pkg::cmd_t   cmd,
    output logic            done,
    output pwt_pkg::result_t result
);

    import pwt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PROC,
        ST_HEAD,
        ST_HWAIT,
        ST_TWAIT
    } state_t;

    state_t           state_reg;
    mode_t            op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [PRI_W-1:0] pri_reg;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    occ_reg;
    logic             found_reg;
    entry_t           carry_reg;
    logic             ok_reg;
    logic             full_reg;
    logic [PRI_W-1:0] fpri_reg;
    entry_t           head_reg;
    logic             done_reg;
    result_t          result_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [EW-1:0]    mem_rdata;
    entry_t           rd_entry;

    logic             at_end;
    logic             at_last;
    logic             take_slot;
    logic [CW-1:0]    idx_dec;
    logic [CW-1:0]    occ_dec;
    logic [CW+COUNT_W-1:0] occ_ext;

    assign rd_entry  = entry_t'(mem_rdata);
    assign at_end    = (idx_reg == occ_reg);
    assign at_last   = (CW'(idx_reg + 1'b1) == occ_reg);
    assign take_slot = at_end || (rd_entry.pri <= pri_reg);
    assign idx_dec   = CW'(idx_reg - 1'b1);
    assign occ_dec   = CW'(occ_reg - 1'b1);
    assign occ_ext   = {{COUNT_W{1'b0}}, occ_reg};

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_READ:
            begin
                mem_re    = 1'b1;
                mem_raddr = idx_reg[AW-1:0];
            end
            ST_HEAD:
            begin
                mem_re    = (occ_reg != '0);
                mem_raddr = '0;
            end
            ST_HWAIT:
            begin
                mem_re    = 1'b1;
                mem_raddr = occ_dec[AW-1:0];
            end
            default:
            begin
                mem_re    = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_wdata = carry_reg;
        if (state_reg == ST_PROC)
        begin
            unique case (op_reg)
                MODE_INSERT:
                begin
                    if (found_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = carry_reg;
                    end
                    else if (take_slot)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = '{id: id_reg, pri: pri_reg};
                    end
                end
                MODE_REMOVE:
                begin
                    if (found_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_dec[AW-1:0];
                        mem_wdata = rd_entry;
                    end
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    pwt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (EW'(mem_wdata)),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            ok_reg    <= 1'b0;
            full_reg  <= 1'b0;
            idx_reg   <= '0;
            op_reg    <= MODE_INSERT;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= cmd.mode;
                        id_reg    <= cmd.warning_id;
                        pri_reg   <= cmd.new_priority;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        ok_reg    <= 1'b0;
                        full_reg  <= 1'b0;
                        fpri_reg  <= '0;
                        unique case (cmd.mode)
                            MODE_INSERT:
                            begin
                                if (occ_reg == CW'(CAPACITY))
                                begin
                                    full_reg  <= 1'b1;
                                    state_reg <= ST_HEAD;
                                end
                                else
                                begin
                                    state_reg <= ST_READ;
                                end
                            end
                            MODE_REMOVE, MODE_LOOKUP:
                            begin
                                state_reg <= (occ_reg == '0) ? ST_HEAD : ST_READ;
                            end
                            MODE_CLEAR:
                            begin
                                occ_reg   <= '0;
                                ok_reg    <= 1'b1;
                                state_reg <= ST_HEAD;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_PROC;
                end
                ST_PROC:
                begin
                    state_reg <= ST_READ;
                    idx_reg   <= CW'(idx_reg + 1'b1);
                    unique case (op_reg)
                        MODE_INSERT:
                        begin
                            carry_reg <= rd_entry;
                            if (take_slot)
                            begin
                                found_reg <= 1'b1;
                            end
                            if (at_end)
                            begin
                                occ_reg   <= CW'(occ_reg + 1'b1);
                                ok_reg    <= 1'b1;
                                state_reg <= ST_HEAD;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (rd_entry.id == id_reg)
                            begin
                                found_reg <= 1'b1;
                            end
                            if (at_last)
                            begin
                                if (found_reg || (rd_entry.id == id_reg))
                                begin
                                    occ_reg <= occ_dec;
                                    ok_reg  <= 1'b1;
                                end
                                state_reg <= ST_HEAD;
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            if (rd_entry.id == id_reg)
                            begin
                                fpri_reg  <= rd_entry.pri;
                                ok_reg    <= 1'b1;
                                state_reg <= ST_HEAD;
                            end
                            else if (at_last)
                            begin
                                state_reg <= ST_HEAD;
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_HEAD;
                        end
                    endcase
                end
                ST_HEAD:
                begin
                    if (occ_reg == '0)
                    begin
                        done_reg                  <= 1'b1;
                        result_reg.done_ok        <= ok_reg;
                        result_reg.table_full     <= full_reg;
                        result_reg.found_priority <= fpri_reg;
                        result_reg.head_valid     <= 1'b0;
                        result_reg.head_id        <= '0;
                        result_reg.head_priority  <= '0;
                        result_reg.tail_id        <= '0;
                        result_reg.entry_count    <= '0;
                        state_reg                 <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_HWAIT;
                    end
                end
                ST_HWAIT:
                begin
                    head_reg  <= rd_entry;
                    state_reg <= ST_TWAIT;
                end
                ST_TWAIT:
                begin
                    done_reg                  <= 1'b1;
                    result_reg.done_ok        <= ok_reg;
                    result_reg.table_full     <= full_reg;
                    result_reg.found_priority <= fpri_reg;
                    result_reg.head_valid     <= 1'b1;
                    result_reg.head_id        <= head_reg.id;
                    result_reg.head_priority  <= head_reg.pri;
                    result_reg.tail_id        <= rd_entry.id;
                    result_reg.entry_count    <= occ_ext[COUNT_W-1:0];
                    state_reg                 <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("entry RAM read and write hit the same slot");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_full_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.table_full) |-> !result_reg.done_ok)
        else $error("rejected insert reported as stored");
`endif

endmodule
